@@ rtl/mexp_pkg.sv @@
// mexp_pkg: shared types and constants for the modular exponentiation block
// no dependencies; imported by mexp_mulmod and modular_exponentiation
package mexp_pkg;

   // fixed field widths of the stream and register ports
   localparam int BASE_WIDTH     = 64;
   localparam int EXP_WIDTH      = 64;
   localparam int RESULT_WIDTH   = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int REQ_DATA_WIDTH = BASE_WIDTH + EXP_WIDTH;

   // register map, indexed by word address
   localparam logic REG_MODULUS = 1'b0;

   localparam logic [CSR_DATA_WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_REDUCE = 6'b000010,
      S_FIX    = 6'b000100,
      S_EXP    = 6'b001000,
      S_WAIT   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

endpackage

@@ rtl/mexp_mulmod.sv @@
// mexp_mulmod: bit-serial shift-add modular multiplier, one multiplier bit per cycle
// depends on mexp_pkg; operands must be below the modulus
module mexp_mulmod
   import mexp_pkg::*;
#(
   parameter int MODULUS_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [MODULUS_BITS-1:0] a_operand,
   input  logic [MODULUS_BITS-1:0] b_operand,
   input  logic [MODULUS_BITS-1:0] modulus,
   output logic                    done,
   output logic [MODULUS_BITS-1:0] product
);

   localparam int CNT_BITS = (MODULUS_BITS > 1) ? $clog2(MODULUS_BITS) : 1;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [MODULUS_BITS-1:0] acc_ff, acc_in;
   logic [MODULUS_BITS-1:0] a_ff, a_in;
   logic [MODULUS_BITS-1:0] b_ff, b_in;

   logic [MODULUS_BITS:0] mod_ext;
   logic [MODULUS_BITS:0] dbl, dbl_red, sum, sum_red;

   // msb-first horner step: acc = 2*acc + bit*a, kept below the modulus
   always_comb begin
      mod_ext = {1'b0, modulus};
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      sum     = dbl_red + (b_ff[MODULUS_BITS-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(MODULUS_BITS - 1);
         acc_in  = '0;
         a_in    = a_operand;
         b_in    = b_operand;
      end else if (busy_ff) begin
         acc_in = sum_red[MODULUS_BITS-1:0];
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ rtl/modular_exponentiation.sv @@
// modular_exponentiation: top level, base^exponent mod p by square-and-multiply
// depends on mexp_pkg and mexp_mulmod
//
// usage
//  - req stream: one beat carries a signed 64-bit base and a signed exponent
//  - rsp stream: one beat per request, the residue base^exponent mod p
//  - csr apb port: register 0 (byte address 0) holds the modulus p,
//    reset value 1000000007; write only while the block is idle
//  - p of zero or one, or a base that reduces to zero, answers 0;
//    otherwise an exponent of zero or below answers 1
//  - sequence: an accept state, bit-serial reduction of the 64-bit base,
//    a fix-up state, then per exponent bit up to the highest set one a
//    square-and-multiply round, then the done state and the output register
//  - the rate is set by the two shift-add modular multipliers, which run
//    the square and the multiply side by side one bit per cycle
//  - one item at a time: req_tready is high only when the engine is idle,
//    also while an earlier result still sits in the output register
//  - a stalled rsp side holds the result; the engine waits in its done
//    state until the output register frees up
//  - reset returns the engine to idle, drops rsp_tvalid and reloads p
module modular_exponentiation
   import mexp_pkg::*;
#(
   parameter int MODULUS_BITS  = 32,
   parameter int EXPONENT_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // request stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // base_value[63:0], exponent[127:64]
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RESULT_WIDTH-1:0]   rsp_tdata,   // power_residue[31:0]
   // register port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int RCNT_BITS = $clog2(BASE_WIDTH);

   // registers
   state_type                state_ff, state_in;
   logic [MODULUS_BITS-1:0]  modulus_ff, modulus_in;
   logic [MODULUS_BITS-1:0]  m_cur_ff, m_cur_in;      // modulus frozen for this item
   logic [BASE_WIDTH-1:0]    base_ff, base_in;        // magnitude, shifted out msb first
   logic                     neg_ff, neg_in;
   logic [EXPONENT_BITS-1:0] exp_ff, exp_in;
   logic [MODULUS_BITS-1:0]  red_ff, red_in;          // running remainder of the base
   logic [RCNT_BITS-1:0]     rcnt_ff, rcnt_in;
   logic [MODULUS_BITS-1:0]  res_ff, res_in;          // running result
   logic [MODULUS_BITS-1:0]  x_ff, x_in;              // running power of the base
   logic [MODULUS_BITS-1:0]  result_ff, result_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RESULT_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   // datapath signals
   logic [BASE_WIDTH-1:0]    req_base;
   logic [EXPONENT_BITS-1:0] req_exp;
   logic                     req_accept;
   logic                     csr_write;
   logic [MODULUS_BITS:0]    red_shift, red_sub, m_ext;
   logic [MODULUS_BITS-1:0]  x_fix;
   logic                     rsp_load;
   logic                     mul_start;
   logic                     mul_done_r, mul_done_s;
   logic [MODULUS_BITS-1:0]  mul_prod_r, mul_prod_s;

   assign req_base   = req_tdata[BASE_WIDTH-1:0];
   assign req_exp    = req_tdata[BASE_WIDTH +: EXPONENT_BITS];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // register port, word addressed
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == REG_MODULUS);
   assign csr_prdata = (csr_paddr[2] == REG_MODULUS) ? CSR_DATA_WIDTH'(modulus_ff) : '0;
   assign modulus_in = csr_write ? MODULUS_BITS'(csr_pwdata) : modulus_ff;

   // one restoring-division bit of the base per cycle
   always_comb begin
      m_ext     = {1'b0, m_cur_ff};
      red_shift = {red_ff, base_ff[BASE_WIDTH-1]};
      red_sub   = red_shift - m_ext;
      x_fix     = (neg_ff && (red_ff != '0)) ? (m_cur_ff - red_ff) : red_ff;
   end

   // result multiply and base square share the same operand snapshot
   mexp_mulmod #(.MODULUS_BITS(MODULUS_BITS)) u_mul_res (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .a_operand (res_ff),
      .b_operand (x_ff),
      .modulus   (m_cur_ff),
      .done      (mul_done_r),
      .product   (mul_prod_r)
   );

   mexp_mulmod #(.MODULUS_BITS(MODULUS_BITS)) u_mul_sq (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .a_operand (x_ff),
      .b_operand (x_ff),
      .modulus   (m_cur_ff),
      .done      (mul_done_s),
      .product   (mul_prod_s)
   );

   always_comb begin
      state_in  = state_ff;
      m_cur_in  = m_cur_ff;
      base_in   = base_ff;
      neg_in    = neg_ff;
      exp_in    = exp_ff;
      red_in    = red_ff;
      rcnt_in   = rcnt_ff;
      res_in    = res_ff;
      x_in      = x_ff;
      result_in = result_ff;
      mul_start = 1'b0;
      rsp_load  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               m_cur_in = modulus_ff;
               neg_in   = req_base[BASE_WIDTH-1];
               base_in  = req_base[BASE_WIDTH-1] ? (BASE_WIDTH'(0) - req_base) : req_base;
               exp_in   = req_exp;
               red_in   = '0;
               rcnt_in  = RCNT_BITS'(BASE_WIDTH - 1);
               if (modulus_ff == '0) begin
                  // zero modulus answers zero
                  result_in = '0;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            red_in  = red_sub[MODULUS_BITS] ? red_shift[MODULUS_BITS-1:0]
                                            : red_sub[MODULUS_BITS-1:0];
            base_in = base_ff << 1;
            rcnt_in = rcnt_ff - 1'b1;
            if (rcnt_ff == '0) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            x_in   = x_fix;
            res_in = MODULUS_BITS'(1);
            if (x_fix == '0) begin
               result_in = '0;
               state_in  = S_DONE;
            end else if (exp_ff[EXPONENT_BITS-1]) begin
               // negative exponent with a nonzero base
               result_in = MODULUS_BITS'(1);
               state_in  = S_DONE;
            end else begin
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            if (exp_ff == '0) begin
               result_in = res_ff;
               state_in  = S_DONE;
            end else begin
               mul_start = 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (mul_done_r) begin
               res_in   = exp_ff[0] ? mul_prod_r : res_ff;
               x_in     = mul_prod_s;
               exp_in   = exp_ff >> 1;
               state_in = S_EXP;
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: holds the beat until the receiver takes it
   assign rsp_tvalid_in = rsp_load || (rsp_tvalid_ff && !rsp_tready);
   assign rsp_data_in   = rsp_load ? RESULT_WIDTH'(result_ff) : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         modulus_ff    <= MODULUS_BITS'(MODULUS_RESET);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         modulus_ff    <= modulus_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      m_cur_ff    <= m_cur_in;
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      exp_ff      <= exp_in;
      red_ff      <= red_in;
      rcnt_ff     <= rcnt_in;
      res_ff      <= res_in;
      x_ff        <= x_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // an accepted beat always takes the engine out of idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("engine stayed idle after an accepted request");

   // both multipliers run in lockstep and only finish while awaited
   a_mul_lockstep: assert property (@(posedge clock) disable iff (reset)
      (mul_done_r == mul_done_s) && (!mul_done_r || state_ff == S_WAIT))
      else $error("multiplier completion out of step");

   // running power stays a proper residue during exponentiation
   a_x_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXP) |-> (x_ff < m_cur_ff) && (res_ff < m_cur_ff))
      else $error("operand not reduced below the modulus");

   // a delivered result is below a nonzero modulus
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && m_cur_ff != '0) |-> (result_ff < m_cur_ff))
      else $error("result not reduced below the modulus");

   // the engine never overwrites a result still waiting in the output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |-> !rsp_load)
      else $error("output register overwritten while stalled");
`endif

endmodule

@@ verif/modular_exponentiation_tb.sv @@
// modular_exponentiation_tb: self-checking bench for base^exponent mod p over the stream ports
// depends on mexp_pkg and the modular_exponentiation rtl; stimulus, prediction and checks live here
`timescale 1ns / 100ps

module modular_exponentiation_tb
   import mexp_pkg::*;
();

   // one request beat: exponent in the upper half of tdata, base in the lower half
   typedef struct packed {
      logic [EXP_WIDTH-1:0]  exponent;
      logic [BASE_WIDTH-1:0] base_value;
   } req_item_type;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   // the tail outlasts the worst case for one more item
   localparam int unsigned TAIL_CYCLES = 2400;
   // long rsp hold-off, long enough to park one result and fill the engine behind it
   localparam int unsigned HOLD_CYCLES = 6000;
   localparam int unsigned HOLD_AT     = 40;
   localparam int unsigned IDLE_PCT    = 16;
   localparam logic [31:0] BIG_PRIME   = 32'd4294967291;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;   // base_value[63:0], exponent[127:64]

   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RESULT_WIDTH-1:0]   rsp_tdata;         // power_residue[31:0]

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   modular_exponentiation u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench state
   req_item_type           pending_beats[$];      // requests not yet offered
   logic [RESULT_WIDTH-1:0] expected_residues[$]; // predicted results, oldest first
   req_item_type           next_beat;
   logic [31:0]            active_modulus = MODULUS_RESET;  // mirror of the modulus register
   logic                   steady = 1'b0;         // no random idling on either side
   logic                   hold_used = 1'b0;
   int unsigned            hold_left = 0;
   int unsigned            beats_accepted = 0;
   int unsigned            residues_seen = 0;
   int unsigned            modulus_settings = 1;
   int unsigned            fail_count = 0;
   int unsigned            cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // base^exponent mod p, square-and-multiply from the low exponent bit up
   function automatic logic [31:0] predict_power(logic [63:0] base_value, logic [63:0] exponent,
                                                 logic [31:0] p);
      longint unsigned m, x, acc, e, mag;
      if (p == 32'd0) return 32'd0;
      m = p;
      // negative base: take the residue of the magnitude and fold it back
      if (base_value[63]) begin
         mag = 64'd0 - base_value;
         x = mag % m;
         if (x != 0) x = m - x;
      end else begin
         x = base_value % m;
      end
      // a zero residue wins over every exponent, zero and negative included
      if (x == 0) return 32'd0;
      acc = 1 % m;
      // zero or negative exponent leaves the 1
      if (!exponent[63]) begin
         e = exponent;
         while (e != 0) begin
            if (e[0]) acc = (acc * x) % m;
            e = e >> 1;
            x = (x * x) % m;
         end
      end
      return acc[31:0];
   endfunction

   function automatic logic [63:0] random_base(logic [31:0] p);
      logic [63:0] v;
      case ($urandom_range(9))
         0, 1, 2: v = {$urandom, $urandom};
         3:       v = 64'($urandom_range(1000));
         4:       v = -64'($urandom_range(1000, 1));
         // exact multiples of p, either sign, reduce to zero
         5: begin
            v = 64'(p) * 64'($urandom_range(1 << 20));
            if ($urandom_range(1)) v = -v;
         end
         6: begin
            case ($urandom_range(2))
               0:       v = 64'(p) - 64'd1;
               1:       v = 64'(p) + 64'd1;
               default: v = 64'd1 - 64'(p);
            endcase
         end
         7: begin
            case ($urandom_range(3))
               0:       v = 64'h8000_0000_0000_0000;
               1:       v = 64'h7FFF_FFFF_FFFF_FFFF;
               2:       v = 64'hFFFF_FFFF_FFFF_FFFF;
               default: v = 64'd0;
            endcase
         end
         default: v = 64'($urandom);
      endcase
      return v;
   endfunction

   // most exponents are short so the run stays fast; a third use all 64 bits
   function automatic logic [63:0] random_exponent();
      logic [63:0] v;
      logic [63:0] mask;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0, 1, 2: ;
         3, 4, 5: begin
            mask = (64'd1 << $urandom_range(16, 1)) - 64'd1;
            v = v & mask;
         end
         6, 7: begin
            mask = (64'd1 << $urandom_range(63, 17)) - 64'd1;
            v = v & mask;
         end
         8: v[63] = 1'b1;
         default: begin
            case ($urandom_range(5))
               0:       v = 64'd0;
               1:       v = 64'd1;
               2:       v = 64'd2;
               3:       v = 64'h7FFF_FFFF_FFFF_FFFF;
               4:       v = 64'h8000_0000_0000_0000;
               default: v = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic queue_beat(logic [63:0] base_value, logic [63:0] exponent);
      req_item_type item;
      item.base_value = base_value;
      item.exponent   = exponent;
      pending_beats.insert(pending_beats.size(), item);
   endtask

   // sender is paused here until every result is back and the engine is idle;
   // sampled just after the edge so the driver's updates for that edge are seen
   task automatic drain();
      @(posedge clock);
      #1;
      while (pending_beats.size() != 0 || req_tvalid || expected_residues.size() != 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic run_random(int unsigned count);
      repeat (count) queue_beat(random_base(active_modulus), random_exponent());
      drain();
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic write_modulus(logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(REG_MODULUS) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      active_modulus = value;
      modulus_settings++;
   endtask

   // request driver: pops the pending queue, predicts each beat as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_residues.insert(expected_residues.size(),
                                     predict_power(req_tdata[BASE_WIDTH-1:0],
                                                   req_tdata[REQ_DATA_WIDTH-1:BASE_WIDTH],
                                                   active_modulus));
            beats_accepted++;
         end
         // one nonblocking write to tvalid per edge, so back-to-back beats keep it high
         if (!req_tvalid || req_tready) begin
            if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               next_beat = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {next_beat.exponent, next_beat.base_value};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and rsp backpressure, including one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            residues_seen++;
            if (expected_residues.size() == 0) begin
               $error("power_residue: unexpected beat, actual %0d", rsp_tdata);
               fail_count++;
            end else if (rsp_tdata !== expected_residues[0]) begin
               $error("power_residue: expected %0d, actual %0d", expected_residues[0],
                      rsp_tdata);
               fail_count++;
               void'(expected_residues.pop_front());
            end else begin
               void'(expected_residues.pop_front());
            end
         end
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_used && residues_seen == HOLD_AT) begin
            // sender keeps offering, so the engine fills and req_tready drops
            hold_used  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("modular_exponentiation verification failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed beats at the reset modulus: zero residues, zero and negative
      // exponents, negative bases and the extremes of both fields
      queue_beat(64'd0, 64'd0);
      queue_beat(64'd5, 64'd0);
      queue_beat(64'd5, -64'd3);
      queue_beat(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_beat(64'd1000000007, 64'd5);
      queue_beat(-64'd1000000007, 64'd7);
      queue_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
      queue_beat(-64'd2, 64'd10);
      queue_beat(-64'd7, 64'd1);
      queue_beat(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_beat(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_beat(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
      queue_beat(64'd2, 64'd1);
      queue_beat(64'd3, 64'd2);
      queue_beat(64'd12345, 64'h0000_0000_FFFF_FFFF);
      queue_beat(64'd2, 64'h5555_5555_5555_5555);
      queue_beat(64'hAAAA_AAAA_AAAA_AAAA, 64'h2AAA_AAAA_AAAA_AAAA);
      queue_beat(64'd1000000006, 64'd2);
      queue_beat(64'd1000000008, 64'd1000000006);
      drain();

      // random traffic at the reset modulus; the long rsp hold-off lands here
      run_random(100);

      // zero and one moduli always answer zero
      write_modulus(32'd0);
      queue_beat(64'd5, 64'd0);
      run_random(10);
      write_modulus(32'd1);
      queue_beat(64'd5, 64'd0);
      run_random(10);
      write_modulus(32'd2);
      run_random(15);

      // largest modulus with both sides always ready
      write_modulus(32'hFFFF_FFFF);
      steady = 1'b1;
      queue_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_beat(64'h0000_0000_FFFF_FFFE, 64'd2);
      run_random(40);
      steady = 1'b0;

      write_modulus(BIG_PRIME);
      run_random(40);
      write_modulus($urandom | 32'd2);
      run_random(40);
      write_modulus(32'd3);
      run_random(15);
      write_modulus(MODULUS_RESET);
      run_random(10);

      // quiet tail: nothing further may come out
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_residues.size() != 0) begin
         $error("power_residue: %0d expected beats never arrived", expected_residues.size());
         fail_count++;
      end

      $display("covered %0d request beats and %0d result beats over %0d modulus settings",
               beats_accepted, residues_seen, modulus_settings);
      $display("moduli included 0, 1, 2, 3, 2^32-1, a large prime and the reset value");
      if (fail_count == 0) begin
         $display("modular_exponentiation verification clean");
      end else begin
         $display("modular_exponentiation verification failed");
      end
      $finish;
   end

endmodule
